/* hdl/trws_pkg.sv */
package trws_pkg;

    localparam int MAX_EVENTS = 1024;
    localparam int MAX_BURST  = 64;

    localparam int IDX_W   = $clog2(MAX_EVENTS);
    localparam int POS_W   = IDX_W + 1;
    localparam int CNT_W   = $clog2(MAX_BURST) + 1;
    localparam int TICK_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3 * BYTE_W;
    localparam int LEN_W   = 11;
    localparam int LOOP_W  = 10;
    localparam int OP_W    = 3;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_START  = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 1'd1;

    typedef struct packed {
        logic [TICK_W-1:0] base;
        logic [BYTE_W-1:0] addend;
        logic [TICK_W-1:0] due;
        logic              cmp_sum;
    } alu_req_t;

    typedef struct packed {
        logic [TICK_W-1:0] sum;
        logic              due_le;
    } alu_rsp_t;

endpackage

/* hdl/trws_event_mem.sv */
module trws_event_mem (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [trws_pkg::IDX_W-1:0]          wr_addr,
    input  logic [trws_pkg::EVENT_W-1:0]        wr_data,
    input  logic [trws_pkg::IDX_W-1:0]          rd_addr,
    output logic [trws_pkg::EVENT_W-1:0]        rd_data
);

    logic [trws_pkg::EVENT_W-1:0] mem [trws_pkg::MAX_EVENTS];
    logic [trws_pkg::EVENT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/trws_alu.sv */
module trws_alu (
    input  trws_pkg::alu_req_t req,
    output trws_pkg::alu_rsp_t rsp
);

    logic [trws_pkg::TICK_W-1:0] sum;
    logic [trws_pkg::TICK_W-1:0] lhs;

    assign sum     = req.base + {{(trws_pkg::TICK_W - trws_pkg::BYTE_W){1'b0}}, req.addend};
    assign lhs     = req.cmp_sum ? sum : req.due;
    assign rsp.sum = sum;
    assign rsp.due_le = (lhs <= req.base);

endmodule

/* hdl/timed_register_write_sequencer_top.sv */
// Timed register write sequencer.
// Slave stream: tuser = operation (tick, load, start, stop, resume);
//   tdata = event_index, event_delay, event_address, event_data from bit 0 up.
// Master stream: tdata = write_address, write_data; tlast marks the final
//   write of a tick. Only ticks produce words.
// Configuration: cfg_we/cfg_index/cfg_data write song_length (0) and
//   loop_start (1); write them only while idle (the block does not enforce this).
// Load, start, stop, resume and idle ticks are handled in ST_IDLE. A playing
//   tick passes ST_CHECK and ST_EMIT for each emitted write, then ST_FINISH, for
//   a burst of up to 64 writes: each write reads the event memory (one registered read port)
//   and then runs the shared 32-bit add and compare unit for the next due time.
// s_tready is low while a tick is in progress.
// A stalled master holds the current word in the output register and the tick
//   waits until it is taken.
// Reset clears play position, tick counts, play flag and registers; the event
//   memory holds no defined contents until loaded.
module timed_register_write_sequencer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [39:0]                         s_tdata,  // event_index, event_delay, event_address, event_data
    input  logic [trws_pkg::OP_W-1:0]           s_tuser,  // operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,  // write_address, write_data
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [trws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trws_pkg::CFG_W-1:0]          cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [trws_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [trws_pkg::TICK_W-1:0]    elapsed_reg, elapsed_next;
    logic [trws_pkg::TICK_W-1:0]    due_reg, due_next;
    logic                           playing_reg, playing_next;
    logic [trws_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [trws_pkg::LEN_W-1:0]     song_len_reg;
    logic [trws_pkg::LOOP_W-1:0]    loop_start_reg;
    logic                           m_valid_reg, m_valid_next;
    logic [15:0]                    m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;

    logic [trws_pkg::POS_W-1:0]     len;
    logic [trws_pkg::POS_W-1:0]     loop_ext;
    logic [trws_pkg::POS_W-1:0]     pos_inc;
    logic [trws_pkg::CNT_W-1:0]     count_inc;
    logic [trws_pkg::EVENT_W-1:0]   rd_data;
    logic                           accept;
    logic                           load_en;
    logic                           out_free;
    logic [trws_pkg::OP_W-1:0]      op;
    logic [trws_pkg::IDX_W-1:0]     ev_index;
    logic [trws_pkg::EVENT_W-1:0]   ev_word;
    trws_pkg::alu_req_t             alu_req;
    trws_pkg::alu_rsp_t             alu_rsp;

    assign op       = s_tuser;
    assign ev_index = s_tdata[9:0];
    assign ev_word  = {s_tdata[17:10], s_tdata[25:18], s_tdata[33:26]};
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_en  = accept && (op == trws_pkg::OP_LOAD);
    assign out_free = !m_valid_reg || m_tready;

    assign len = (song_len_reg > trws_pkg::LEN_W'(trws_pkg::MAX_EVENTS))
               ? trws_pkg::POS_W'(trws_pkg::MAX_EVENTS)
               : trws_pkg::POS_W'(song_len_reg);
    assign loop_ext  = trws_pkg::POS_W'(loop_start_reg);
    assign pos_inc   = pos_reg + 1'b1;
    assign count_inc = count_reg + 1'b1;

    trws_event_mem u_mem (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (ev_index),
        .wr_data (ev_word),
        .rd_addr (pos_reg[trws_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        alu_req.base    = elapsed_reg;
        alu_req.due     = due_reg;
        alu_req.cmp_sum = (state_reg == ST_EMIT);
        alu_req.addend  = (state_reg == ST_EMIT) ? rd_data[23:16] : trws_pkg::BYTE_W'(1);
    end

    trws_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            song_len_reg   <= '0;
            loop_start_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                trws_pkg::REG_SONG_LENGTH: song_len_reg   <= cfg_data;
                trws_pkg::REG_LOOP_START:  loop_start_reg <= cfg_data[trws_pkg::LOOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        elapsed_next = elapsed_reg;
        due_next     = due_reg;
        playing_next = playing_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        trws_pkg::OP_TICK: begin
                            if (playing_reg) begin
                                count_next = '0;
                                state_next = ST_CHECK;
                            end
                        end
                        trws_pkg::OP_START: begin
                            pos_next     = '0;
                            elapsed_next = '0;
                            due_next     = '0;
                            playing_next = 1'b1;
                        end
                        trws_pkg::OP_STOP:   playing_next = 1'b0;
                        trws_pkg::OP_RESUME: playing_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                if (count_reg < trws_pkg::CNT_W'(trws_pkg::MAX_BURST) && pos_reg < len
                    && alu_rsp.due_le) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {rd_data[7:0], rd_data[15:8]};
                    m_last_next  = !(count_inc < trws_pkg::CNT_W'(trws_pkg::MAX_BURST)
                                     && pos_inc < len && alu_rsp.due_le);
                    due_next     = alu_rsp.sum;
                    pos_next     = pos_inc;
                    count_next   = count_inc;
                    state_next   = ST_CHECK;
                end
            end
            ST_FINISH: begin
                elapsed_next = alu_rsp.sum;
                if (pos_reg >= len) begin
                    pos_next     = (loop_ext < len) ? loop_ext : '0;
                    elapsed_next = '0;
                    due_next     = '0;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            elapsed_reg <= '0;
            due_reg     <= '0;
            playing_reg <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            elapsed_reg <= elapsed_next;
            due_reg     <= due_next;
            playing_reg <= playing_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
